// File: sv/clp_pkg.sv
// Shared types, constants and helpers for the circular list position engine.
package clp_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    // Wide enough for a position, a count plus one, and their compare.
    localparam int CMP_BITS   = 8;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_POS   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        STAT_OK     = 3'd0,
        STAT_EMPTY  = 3'd1,
        STAT_BADPOS = 3'd2,
        STAT_FULL   = 3'd3,
        STAT_BADOP  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_INS_FREE,
        ST_WALK,
        ST_INS_FIX,
        ST_DEL_READ,
        ST_DEL_FREE
    } t_state;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [6:0]         position;
    } t_in;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [2:0]         status;
        logic [6:0]         element_count;
    } t_out;

    // Requests from the sequencer to the list store.
    typedef struct packed {
        logic                  link_we;
        logic [SLOT_BITS-1:0]  link_waddr;
        logic [SLOT_BITS-1:0]  link_wdata;
        logic [SLOT_BITS-1:0]  link_raddr;
        logic                  val_we;
        logic [SLOT_BITS-1:0]  val_waddr;
        logic [VALUE_BITS-1:0] val_wdata;
        logic [SLOT_BITS-1:0]  val_raddr;
    } t_mem_req;

    // Registered read data from the list store.
    typedef struct packed {
        logic [SLOT_BITS-1:0]  link_rdata;
        logic [VALUE_BITS-1:0] val_rdata;
    } t_mem_rsp;

    // Sign-extend the input value, then keep the stored width.
    function automatic logic [VALUE_BITS-1:0] to_store(input logic signed [31:0] v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[VALUE_BITS-1:0];
    endfunction

    // Zero-extend a stored value, then keep the low 32 bits.
    function automatic logic [31:0] from_store(input logic [VALUE_BITS-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[31:0];
    endfunction

endpackage

// File: sv/clp_store.sv
// Value and link memories of the list, each with one write and one registered read port.
module clp_store (
    input  logic              i_clk,
    input  clp_pkg::t_mem_req i_req,
    output clp_pkg::t_mem_rsp o_rsp
);
    import clp_pkg::*;

    logic [SLOT_BITS-1:0]  r_link_mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_val_mem  [CAPACITY];
    logic [SLOT_BITS-1:0]  r_link_rdata;
    logic [VALUE_BITS-1:0] r_val_rdata;

    // Link memory: write, and registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.link_we) begin
            r_link_mem[i_req.link_waddr] <= i_req.link_wdata;
        end
        r_link_rdata <= r_link_mem[i_req.link_raddr];
    end

    // Value memory: write, and registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.val_we) begin
            r_val_mem[i_req.val_waddr] <= i_req.val_wdata;
        end
        r_val_rdata <= r_val_mem[i_req.val_raddr];
    end

    assign o_rsp.link_rdata = r_link_rdata;
    assign o_rsp.val_rdata  = r_val_rdata;

endmodule

// File: sv/clp_ctrl.sv
// Sequencer that decodes list commands, walks links and updates the list store.
module clp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  clp_pkg::t_in      i_in,
    output logic              o_busy,
    output logic              o_done,
    output clp_pkg::t_out     o_result,
    output clp_pkg::t_mem_req o_req,
    input  clp_pkg::t_mem_rsp i_rsp
);
    import clp_pkg::*;

    t_state                r_state, n_state;
    logic [SLOT_BITS-1:0]  r_tail, n_tail;
    logic [SLOT_BITS-1:0]  r_free, n_free;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [SLOT_BITS-1:0]  r_init_addr, n_init_addr;
    logic                  r_is_del, n_is_del;
    logic                  r_ins_end, n_ins_end;
    logic [SLOT_BITS-1:0]  r_new, n_new;
    logic [SLOT_BITS-1:0]  r_cur, n_cur;
    logic [SLOT_BITS-1:0]  r_steps, n_steps;
    logic [SLOT_BITS-1:0]  r_prev, n_prev;
    logic [SLOT_BITS-1:0]  r_victim, n_victim;
    logic                  r_done, n_done;
    t_out                  r_result, n_result;

    logic                  accept;
    logic                  is_ins, is_del;
    logic [CMP_BITS-1:0]   cnt_ext, ins_p, del_p;
    logic [2:0]            dec_status;
    logic                  dec_go;
    logic [SLOT_BITS-1:0]  init_next;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign cnt_ext   = CMP_BITS'(r_count);
    assign init_next = (r_init_addr == SLOT_BITS'(CAPACITY - 1)) ? '0 : r_init_addr + 1'b1;

    // Command decode: effective position and error status.
    always_comb begin
        is_ins = (i_in.op == OP_INS_FRONT) || (i_in.op == OP_INS_END) ||
                 (i_in.op == OP_INS_POS);
        is_del = (i_in.op == OP_DEL_FRONT) || (i_in.op == OP_DEL_END) ||
                 (i_in.op == OP_DEL_POS);
        ins_p  = (i_in.op == OP_INS_FRONT) ? CMP_BITS'(1) :
                 (i_in.op == OP_INS_END)   ? cnt_ext + 1'b1 : CMP_BITS'(i_in.position);
        del_p  = (i_in.op == OP_DEL_FRONT) ? CMP_BITS'(1) :
                 (i_in.op == OP_DEL_END)   ? cnt_ext : CMP_BITS'(i_in.position);
        dec_status = STAT_OK;
        if (is_ins) begin
            if ((ins_p == '0) || (ins_p > cnt_ext + 1'b1)) begin
                dec_status = STAT_BADPOS;
            end else if (cnt_ext >= CMP_BITS'(CAPACITY)) begin
                dec_status = STAT_FULL;
            end
        end else if (is_del) begin
            if (r_count == '0) begin
                dec_status = STAT_EMPTY;
            end else if ((del_p == '0) || (del_p > cnt_ext)) begin
                dec_status = STAT_BADPOS;
            end
        end else begin
            dec_status = STAT_BADOP;
        end
        dec_go = (dec_status == STAT_OK);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_init_addr == SLOT_BITS'(CAPACITY - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && dec_go) begin
                    n_state = is_ins ? ST_INS_FREE : ST_WALK;
                end
            end
            ST_INS_FREE: begin
                n_state = (r_count == '0) ? ST_IDLE : ST_WALK;
            end
            ST_WALK: begin
                if (r_steps == '0) begin
                    n_state = r_is_del ? ST_DEL_READ : ST_INS_FIX;
                end
            end
            ST_INS_FIX:  n_state = ST_IDLE;
            ST_DEL_READ: n_state = ST_DEL_FREE;
            ST_DEL_FREE: n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath, memory requests and result.
    always_comb begin
        n_tail      = r_tail;
        n_free      = r_free;
        n_count     = r_count;
        n_init_addr = r_init_addr;
        n_is_del    = r_is_del;
        n_ins_end   = r_ins_end;
        n_new       = r_new;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_prev      = r_prev;
        n_victim    = r_victim;
        n_done      = 1'b0;
        n_result    = r_result;

        o_req            = '0;
        o_req.link_raddr = r_tail;
        o_req.val_raddr  = r_tail;
        o_req.val_wdata  = to_store(i_in.value);

        unique case (r_state)
            ST_INIT: begin
                // Clearing pass: each slot links to the next one.
                o_req.link_we    = 1'b1;
                o_req.link_waddr = r_init_addr;
                o_req.link_wdata = init_next;
                n_init_addr      = init_next;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (!dec_go) begin
                        n_done                 = 1'b1;
                        n_result.removed_value = '0;
                        n_result.status        = dec_status;
                        n_result.element_count = 7'(r_count);
                    end else if (is_ins) begin
                        // Claim the free head slot and fetch its link.
                        o_req.val_we     = 1'b1;
                        o_req.val_waddr  = r_free;
                        o_req.link_raddr = r_free;
                        n_new            = r_free;
                        n_steps          = SLOT_BITS'(ins_p - 1'b1);
                        n_ins_end        = (ins_p == cnt_ext + 1'b1);
                        n_is_del         = 1'b0;
                    end else begin
                        // Start the walk at the tail.
                        o_req.link_raddr = r_tail;
                        n_cur            = r_tail;
                        n_steps          = SLOT_BITS'(del_p - 1'b1);
                        n_is_del         = 1'b1;
                    end
                end
            end
            ST_INS_FREE: begin
                n_free = i_rsp.link_rdata;
                if (r_count == '0) begin
                    // First element links to itself.
                    o_req.link_we          = 1'b1;
                    o_req.link_waddr       = r_new;
                    o_req.link_wdata       = r_new;
                    n_tail                 = r_new;
                    n_count                = r_count + 1'b1;
                    n_done                 = 1'b1;
                    n_result.removed_value = '0;
                    n_result.status        = STAT_OK;
                    n_result.element_count = 7'(r_count + 1'b1);
                end else begin
                    o_req.link_raddr = r_tail;
                    n_cur            = r_tail;
                end
            end
            ST_WALK: begin
                if (r_steps == '0) begin
                    n_prev = r_cur;
                    if (r_is_del) begin
                        n_victim         = i_rsp.link_rdata;
                        o_req.link_raddr = i_rsp.link_rdata;
                        o_req.val_raddr  = i_rsp.link_rdata;
                    end else begin
                        o_req.link_we    = 1'b1;
                        o_req.link_waddr = r_new;
                        o_req.link_wdata = i_rsp.link_rdata;
                    end
                end else begin
                    // Follow one link per cycle.
                    n_cur            = i_rsp.link_rdata;
                    o_req.link_raddr = i_rsp.link_rdata;
                    n_steps          = r_steps - 1'b1;
                end
            end
            ST_INS_FIX: begin
                o_req.link_we    = 1'b1;
                o_req.link_waddr = r_prev;
                o_req.link_wdata = r_new;
                if (r_ins_end) begin
                    n_tail = r_new;
                end
                n_count                = r_count + 1'b1;
                n_done                 = 1'b1;
                n_result.removed_value = '0;
                n_result.status        = STAT_OK;
                n_result.element_count = 7'(r_count + 1'b1);
            end
            ST_DEL_READ: begin
                // Unlink the victim and stage its value.
                if (r_count == COUNT_BITS'(1)) begin
                    n_tail = '0;
                end else begin
                    o_req.link_we    = 1'b1;
                    o_req.link_waddr = r_prev;
                    o_req.link_wdata = i_rsp.link_rdata;
                    if (r_victim == r_tail) begin
                        n_tail = r_prev;
                    end
                end
                n_result.removed_value = from_store(i_rsp.val_rdata);
            end
            ST_DEL_FREE: begin
                // Return the victim slot to the free chain.
                o_req.link_we          = 1'b1;
                o_req.link_waddr       = r_victim;
                o_req.link_wdata       = r_free;
                n_free                 = r_victim;
                n_count                = r_count - 1'b1;
                n_done                 = 1'b1;
                n_result.status        = STAT_OK;
                n_result.element_count = 7'(r_count - 1'b1);
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_tail      <= '0;
            r_free      <= '0;
            r_count     <= '0;
            r_init_addr <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tail      <= n_tail;
            r_free      <= n_free;
            r_count     <= n_count;
            r_init_addr <= n_init_addr;
            r_done      <= n_done;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge i_clk) begin
        r_is_del  <= n_is_del;
        r_ins_end <= n_ins_end;
        r_new     <= n_new;
        r_cur     <= n_cur;
        r_steps   <= n_steps;
        r_prev    <= n_prev;
        r_victim  <= n_victim;
        r_result  <= n_result;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // The count never exceeds the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(CAPACITY))
        else $error("element count above capacity");

    // A result beat only ever shows while the sequencer is free.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == ST_IDLE))
        else $error("result beat while a command is still running");

    // The count changes only together with a result beat.
    a_count_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |-> r_done)
        else $error("element count changed without a result beat");

endmodule

// File: sv/circular_list_position_engine.sv
// Sequence: an error result shows in the cycle after acceptance; an insert passes INS_FREE,
// WALK, INS_FIX (ending in INS_FREE on an empty list), a delete WALK, DEL_READ, DEL_FREE.
// Throughput: one command at a time; the walk follows one link per cycle through the link
// memory's single read port, and the next command is taken in the cycle its result shows.
// Reset: synchronous, active low; then a clearing pass over every slot rebuilds the
// free chain while busy stays high. The receiver cannot stall: each result beat lasts one cycle.
module circular_list_position_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  clp_pkg::t_in  i_in,
    output logic          busy,
    output logic          o_done,
    output clp_pkg::t_out o_result
);
    import clp_pkg::*;

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    // Command sequencer.
    clp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_in     (i_in),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_result (o_result),
        .o_req    (mem_req),
        .i_rsp    (mem_rsp)
    );

    // Value and link memories.
    clp_store u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

endmodule
